>>> sv/tccw_pkg.sv
`default_nettype none

package tccw_pkg;

    localparam int CHAR_W  = 8;
    localparam int COORD_W = 8;
    localparam int ADDR_W  = 14;
    localparam int COLOR_W = 8;
    localparam int NIB_W   = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF = 8'd10;

    localparam logic OP_PUT_CHAR   = 1'b0;
    localparam logic OP_SET_CURSOR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOUR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOUR = 8'd1;

    typedef struct packed {
        logic [COORD_W-1:0] new_row;
        logic [COORD_W-1:0] new_col;
        logic [CHAR_W-1:0]  char_code;
        logic               opcode;
    } in_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] cell_colour;
        logic [CHAR_W-1:0]  cell_char;
        logic [ADDR_W-1:0]  word_address;
    } cell_t;

    typedef struct packed {
        logic  valid;
        cell_t wr;
    } cell_beat_t;

endpackage

`default_nettype wire

>>> sv/text_console_cursor_writer.sv
// An accepted item's cell write reaches m_* through the input and output registers.
// Throughput: one item per cycle unless m_tready stalls; the cursor update and
// address multiply sit between the input register and the output register.
// Items that write no cell (CR, LF, set cursor, off-grid) never wait on m_tready.
// Reset (aresetn low, synchronous): cursor, colours and both valid flags clear.
`default_nettype none

module text_console_cursor_writer
    import tccw_pkg::*;
#(
    parameter int COLUMNS = 100,
    parameter int ROWS    = 50
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [7:0] char_code, [15:8] new_col, [23:16] new_row
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [0] opcode
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [13:0] word_address, [21:14] cell_char, [29:22] cell_colour, [31:30] zero
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    in_item_t           in_item;
    cell_beat_t         res;
    logic               res_ready;
    logic [COLOR_W-1:0] colour;
    cell_t              m_cell;

    assign in_item.opcode    = s_tuser;
    assign in_item.char_code = s_tdata[7:0];
    assign in_item.new_col   = s_tdata[15:8];
    assign in_item.new_row   = s_tdata[23:16];

    assign m_tdata = {(OUT_DATA_W - $bits(cell_t))'(0), m_cell};

    tccw_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .colour    (colour)
    );

    tccw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .colour    (colour),
        .res       (res),
        .res_ready (res_ready)
    );

    tccw_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_cell    (m_cell)
    );

endmodule

`default_nettype wire

>>> sv/tccw_cfg_regs.sv
`default_nettype none

module tccw_cfg_regs
    import tccw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic [COLOR_W-1:0]         colour
);

    logic [NIB_W-1:0] fg_reg, fg_next;
    logic [NIB_W-1:0] bg_reg, bg_next;

    assign cfg_ready = 1'b1;
    assign colour    = {bg_reg, fg_reg};

    always_comb begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_valid && cfg_index == CFG_FG_COLOUR) begin
            fg_next = cfg_data[NIB_W-1:0];
        end
        if (cfg_valid && cfg_index == CFG_BG_COLOUR) begin
            bg_next = cfg_data[NIB_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= '0;
            bg_reg <= '0;
        end else begin
            fg_reg <= fg_next;
            bg_reg <= bg_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/tccw_cursor.sv
`default_nettype none

module tccw_cursor
    import tccw_pkg::*;
#(
    parameter int COLUMNS = 100,
    parameter int ROWS    = 50
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire in_item_t           in_item,
    input  wire logic [COLOR_W-1:0] colour,
    output cell_beat_t              res,
    input  wire logic               res_ready
);

    localparam int OFF_W = 2 * COORD_W + 1;
    localparam logic [COORD_W-1:0] COLS_LIM = COORD_W'(COLUMNS);
    localparam logic [COORD_W-1:0] ROWS_LIM = COORD_W'(ROWS);
    localparam logic [OFF_W-1:0]   ROW_STRIDE = OFF_W'(2 * COLUMNS);

    logic               valid_reg, valid_next;
    in_item_t           item_reg, item_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;

    logic               is_ctrl;
    logic               produces;
    logic               advance;
    logic [COORD_W-1:0] col_w;
    logic [COORD_W-1:0] row_w;
    logic [COORD_W-1:0] row_lf;
    logic [COORD_W-1:0] row_inc;
    logic [OFF_W-1:0]   addr_full;

    always_comb begin
        row_inc = row_reg + COORD_W'(1);
        row_lf  = (row_inc >= ROWS_LIM) ? '0 : row_inc;
        if (col_reg >= COLS_LIM) begin
            col_w = '0;
            row_w = row_lf;
        end else begin
            col_w = col_reg;
            row_w = row_reg;
        end
        addr_full = OFF_W'({col_w, 1'b0}) + OFF_W'(row_w) * ROW_STRIDE;
        is_ctrl   = item_reg.char_code == CH_CR || item_reg.char_code == CH_LF;
        produces  = item_reg.opcode == OP_PUT_CHAR && !is_ctrl &&
                    col_w < COLS_LIM && row_w < ROWS_LIM;
    end

    assign advance  = valid_reg && (!produces || res_ready);
    assign in_ready = !valid_reg || advance;

    assign res.valid           = valid_reg && produces;
    assign res.wr.word_address = addr_full[ADDR_W-1:0];
    assign res.wr.cell_char    = item_reg.char_code;
    assign res.wr.cell_colour  = colour;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            priority if (item_reg.opcode == OP_SET_CURSOR) begin
                col_next = item_reg.new_col;
                row_next = item_reg.new_row;
            end else if (item_reg.char_code == CH_CR) begin
                col_next = '0;
            end else if (item_reg.char_code == CH_LF) begin
                row_next = row_lf;
            end else begin
                col_next = col_w + COORD_W'(1);
                row_next = row_w;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_ready) begin
            valid_next = in_valid;
            item_next  = in_item;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/tccw_out_reg.sv
`default_nettype none

module tccw_out_reg
    import tccw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cell_beat_t res,
    output logic            res_ready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output cell_t           m_cell
);

    logic  valid_reg, valid_next;
    cell_t cell_reg, cell_next;

    assign res_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_cell    = cell_reg;

    always_comb begin
        valid_next = valid_reg;
        cell_next  = cell_reg;
        if (res_ready) begin
            valid_next = res.valid;
            cell_next  = res.wr;
        end
    end

    always_ff @(posedge aclk) begin
        cell_reg <= cell_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire
